### sv/gls_pkg.sv
// Shared types and constants of the grid line-of-sight block.
// No dependencies; gls_front, gls_back and the top level import this package.
package gls_pkg;

  localparam int DefGridDim  = 256;
  localparam int DefElevBits = 16;
  localparam int FieldW      = 8;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 9;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_VIEW_ROW  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_VIEW_COL  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GRID_ROWS = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_GRID_COLS = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Class of a queued word, decided by the front end.
  typedef enum logic [2:0] {
    K_WRITE,
    K_SKIP,
    K_BAD,
    K_SAME,
    K_WALK
  } kind_e;

  typedef struct packed {
    logic [FieldW-1:0] view_row;
    logic [FieldW-1:0] view_col;
    logic [8:0]        grid_rows;
    logic [8:0]        grid_cols;
  } cfg_t;

endpackage

### sv/gls_fifo.sv
// Short word queue between the front end and the back end.
// Depends on nothing; width and depth come from its parameters.
module gls_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### sv/gls_front.sv
// Front end: takes command words, classifies them and pushes them to the queue.
// Depends on gls_pkg.
module gls_front #(
  parameter int GRID_DIM  = gls_pkg::DefGridDim,
  parameter int ELEV_BITS = gls_pkg::DefElevBits,
  parameter int EW        = 3 + 2 * gls_pkg::FieldW + gls_pkg::DefElevBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       op_i,
  input  logic [gls_pkg::FieldW-1:0] target_row_i,
  input  logic [gls_pkg::FieldW-1:0] target_col_i,
  input  logic signed [15:0]         elevation_i,
  input  gls_pkg::cfg_t              cfg_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output logic [EW-1:0]              push_data_o,
  output logic                       stage_vld_o
);
  import gls_pkg::*;

  logic          stage_vld_q, stage_vld_d;
  logic [EW-1:0] stage_q;
  logic          accept, bad, same, wr_ok;
  logic [31:0]   rows, cols;
  kind_e         kind;

  assign busy        = stage_vld_q && q_full_i;
  assign accept      = start && !busy;
  assign push_o      = stage_vld_q && !q_full_i;
  assign push_data_o = stage_q;
  assign stage_vld_o = stage_vld_q;
  assign stage_vld_d = accept || (stage_vld_q && !push_o);

  always_comb begin
    rows  = (32'(cfg_i.grid_rows) > 32'(GRID_DIM)) ? 32'(GRID_DIM) : 32'(cfg_i.grid_rows);
    cols  = (32'(cfg_i.grid_cols) > 32'(GRID_DIM)) ? 32'(GRID_DIM) : 32'(cfg_i.grid_cols);
    bad   = (32'(target_row_i) >= rows) || (32'(target_col_i) >= cols) ||
            (32'(cfg_i.view_row) >= rows) || (32'(cfg_i.view_col) >= cols);
    same  = (target_row_i == cfg_i.view_row) && (target_col_i == cfg_i.view_col);
    wr_ok = (32'(target_row_i) < 32'(GRID_DIM)) && (32'(target_col_i) < 32'(GRID_DIM));
    if (op_i == OP_WRITE) begin
      kind = wr_ok ? K_WRITE : K_SKIP;
    end else if (bad) begin
      kind = K_BAD;
    end else if (same) begin
      kind = K_SAME;
    end else begin
      kind = K_WALK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= {kind, target_row_i, target_col_i,
                  ELEV_BITS'($unsigned(elevation_i))};
    end
  end

endmodule

### sv/gls_back.sv
// Back end: elevation memory and the sequencer that walks the sight line.
// Depends on gls_pkg; reads words from the queue.
module gls_back #(
  parameter int GRID_DIM  = gls_pkg::DefGridDim,
  parameter int ELEV_BITS = gls_pkg::DefElevBits,
  parameter int EW        = 3 + 2 * gls_pkg::FieldW + gls_pkg::DefElevBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gls_pkg::cfg_t              cfg_i,
  input  logic                       q_empty_i,
  input  logic [EW-1:0]              q_data_i,
  output logic                       q_pop_o,
  output logic                       idle_o,
  output logic                       done_o,
  output logic [gls_pkg::FieldW-1:0] query_row_o,
  output logic [gls_pkg::FieldW-1:0] query_col_o,
  output logic                       visible_o,
  output logic                       status_o
);
  import gls_pkg::*;

  localparam int CW = $clog2(GRID_DIM);
  localparam int AW = 2 * CW;
  localparam int E  = ELEV_BITS;
  localparam int DW = E + 1;
  localparam int PW = CW + 1 + DW;
  localparam int LW = PW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_RDB  = 4'd2;
  localparam logic [3:0] S_DT   = 4'd3;
  localparam logic [3:0] S_PSET = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_ADV  = 4'd6;
  localparam logic [3:0] S_RD0  = 4'd7;
  localparam logic [3:0] S_RD1  = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_CMP  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] st_q;

  logic [E-1:0]        mem [2**AW];
  logic [E-1:0]        rdata_q;
  logic [AW-1:0]       rd_addr;

  kind_e               q_kind;
  logic [FieldW-1:0]   q_row, q_col;
  logic [E-1:0]        q_elev;

  logic [FieldW-1:0]   row_q, col_q;
  logic                done_q, vis_q, stat_q;
  logic [CW-1:0]       tr_q, tc_q, vr, vc;
  logic                pass_q;
  logic [CW-1:0]       n_q, k_q, pm_q, p0_q, f_q, rem_q, quo_q, r_q;
  logic signed [CW:0]  qs_q;
  logic                s_neg_q, dn_neg_q;
  logic signed [E-1:0] ha_q, h0_q;
  logic signed [DW-1:0] dt_q;
  logic signed [PW-1:0] pa_q, pb_q, pc_q;

  logic [CW-1:0]        am, an;
  logic signed [CW:0]   dm, dn;
  logic [CW:0]          n_abs, dn_abs;
  logic [CW:0]          fs;
  logic                 carry;
  logic [CW-1:0]        p1;
  logic signed [DW-1:0] d_a, d_b;
  logic signed [LW-1:0] lhs;
  logic                 pop;

  assign vr      = CW'(cfg_i.view_row);
  assign vc      = CW'(cfg_i.view_col);
  assign q_kind  = kind_e'(q_data_i[EW-1 -: 3]);
  assign q_row   = q_data_i[E + 2*FieldW - 1 -: FieldW];
  assign q_col   = q_data_i[E + FieldW - 1 -: FieldW];
  assign q_elev  = q_data_i[E-1:0];
  assign pop     = (st_q == S_IDLE) && !q_empty_i;
  assign q_pop_o = pop;
  assign idle_o  = (st_q == S_IDLE);

  assign done_o      = done_q;
  assign query_row_o = row_q;
  assign query_col_o = col_q;
  assign visible_o   = vis_q;
  assign status_o    = stat_q;

  // Pass 0 walks row crossings, pass 1 walks column crossings.
  always_comb begin
    if (!pass_q) begin
      am = vr;
      an = vc;
      dm = $signed({1'b0, tr_q}) - $signed({1'b0, vr});
      dn = $signed({1'b0, tc_q}) - $signed({1'b0, vc});
    end else begin
      am = vc;
      an = vr;
      dm = $signed({1'b0, tc_q}) - $signed({1'b0, vc});
      dn = $signed({1'b0, tr_q}) - $signed({1'b0, vr});
    end
    n_abs  = dm[CW] ? (CW + 1)'(-dm) : (CW + 1)'(dm);
    dn_abs = dn[CW] ? (CW + 1)'(-dn) : (CW + 1)'(dn);
    fs     = {1'b0, f_q} + {1'b0, r_q};
    carry  = (fs >= {1'b0, n_q});
    p1     = p0_q + 1'b1;
    d_a    = DW'(h0_q) - DW'(ha_q);
    d_b    = DW'($signed(rdata_q)) - DW'(h0_q);
    lhs    = LW'(pa_q) + LW'(pb_q);
  end

  always_comb begin
    unique case (st_q)
      S_RDA:   rd_addr = {vr, vc};
      S_RDB:   rd_addr = {tr_q, tc_q};
      S_RD1:   rd_addr = pass_q ? {p1, pm_q} : {pm_q, p1};
      default: rd_addr = pass_q ? {p0_q, pm_q} : {pm_q, p0_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop && (q_kind == K_WRITE)) begin
      mem[{CW'(q_row), CW'(q_col)}] <= q_elev;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      done_q <= 1'b0;
      pass_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (pop) begin
            case (q_kind)
              K_BAD: begin
                done_q <= 1'b1;
              end
              K_SAME: begin
                done_q <= 1'b1;
              end
              K_WALK: begin
                st_q <= S_RDA;
              end
              default: ;
            endcase
          end
        end
        S_RDA:  st_q <= S_RDB;
        S_RDB:  st_q <= S_DT;
        S_DT: begin
          pass_q <= 1'b0;
          st_q   <= S_PSET;
        end
        S_PSET: begin
          if (n_abs < (CW + 1)'(2)) begin
            if (pass_q) begin
              st_q <= S_DONE;
            end else begin
              pass_q <= 1'b1;
            end
          end else begin
            st_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_q < n_q) begin
            st_q <= S_ADV;
          end
        end
        S_ADV: st_q <= S_RD0;
        S_RD0: st_q <= S_RD1;
        S_RD1: st_q <= S_MUL;
        S_MUL: st_q <= S_CMP;
        S_CMP: begin
          if (lhs > LW'(pc_q)) begin
            st_q <= S_DONE;
          end else if (k_q == n_q - 1'b1) begin
            if (pass_q) begin
              st_q <= S_DONE;
            end else begin
              pass_q <= 1'b1;
              st_q   <= S_PSET;
            end
          end else begin
            st_q <= S_ADV;
          end
        end
        S_DONE: begin
          done_q <= 1'b1;
          st_q   <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the walk.
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        row_q  <= q_row;
        col_q  <= q_col;
        tr_q   <= CW'(q_row);
        tc_q   <= CW'(q_col);
        vis_q  <= (q_kind == K_SAME);
        stat_q <= (q_kind == K_BAD);
      end
      S_RDB: ha_q <= $signed(rdata_q);
      S_DT:  dt_q <= DW'($signed(rdata_q)) - DW'(ha_q);
      S_PSET: begin
        n_q      <= CW'(n_abs);
        s_neg_q  <= dm[CW];
        dn_neg_q <= dn[CW];
        rem_q    <= CW'(dn_abs);
        quo_q    <= '0;
        k_q      <= '0;
        pm_q     <= am;
        p0_q     <= an;
        f_q      <= '0;
        vis_q    <= 1'b1;
      end
      S_DIV: begin
        if (rem_q >= n_q) begin
          rem_q <= rem_q - n_q;
          quo_q <= quo_q + 1'b1;
        end else if (!dn_neg_q) begin
          qs_q <= $signed({1'b0, quo_q});
          r_q  <= rem_q;
        end else if (rem_q == '0) begin
          qs_q <= -$signed({1'b0, quo_q});
          r_q  <= '0;
        end else begin
          qs_q <= -$signed({1'b0, quo_q}) - $signed((CW + 1)'(1));
          r_q  <= n_q - rem_q;
        end
      end
      S_ADV: begin
        k_q  <= k_q + 1'b1;
        pm_q <= s_neg_q ? pm_q - 1'b1 : pm_q + 1'b1;
        f_q  <= carry ? CW'(fs - {1'b0, n_q}) : CW'(fs);
        p0_q <= CW'($signed({1'b0, p0_q}) + qs_q + $signed({1'b0, carry}));
      end
      S_RD1: h0_q <= $signed(rdata_q);
      S_MUL: begin
        pa_q <= $signed({1'b0, n_q}) * d_a;
        // On an exact grid point the neighbor cell is not part of the height.
        if (f_q == '0) begin
          pb_q <= '0;
        end else begin
          pb_q <= d_b * $signed({1'b0, f_q});
        end
        pc_q <= $signed({1'b0, k_q}) * dt_q;
      end
      S_CMP: begin
        if (lhs > LW'(pc_q)) begin
          vis_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

### sv/grid_line_of_sight_visibility.sv
// Top level of the grid line-of-sight block: config registers, front end,
// word queue and back end. Depends on gls_pkg, gls_front, gls_fifo, gls_back.
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------------------------------
//   command   | start / busy       | op_i, target_row_i, target_col_i, elevation_i
//   result    | done_o (strobe)    | query_row_o, query_col_o, visible_o, status_o
//   config    | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// A write word, or a query outside the grid or at the observer, is handled
// from the popped word alone. A walking query reads the observer and target
// cells, then per pass sets up, runs a quotient loop of |minor| / |major| steps
// and walks the |dr| - 1 plus |dc| - 1 crossings: an advance, two reads on the
// single memory read port, a multiply and a compare each. Reset clears control
// only; the memory reads undefined until written. The result receiver cannot
// stall; a two-word queue lets commands come in while the back end walks.
module grid_line_of_sight_visibility #(
  parameter int GRID_DIM  = gls_pkg::DefGridDim,
  parameter int ELEV_BITS = gls_pkg::DefElevBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op_i,
  input  logic [gls_pkg::FieldW-1:0]   target_row_i,
  input  logic [gls_pkg::FieldW-1:0]   target_col_i,
  input  logic signed [15:0]           elevation_i,
  input  logic                         cfg_we_i,
  input  logic [gls_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gls_pkg::CfgDataW-1:0] cfg_wdata_i,
  output logic                         done_o,
  output logic [gls_pkg::FieldW-1:0]   query_row_o,
  output logic [gls_pkg::FieldW-1:0]   query_col_o,
  output logic                         visible_o,
  output logic                         status_o
);
  import gls_pkg::*;

  localparam int EW = $bits(kind_e) + 2 * FieldW + ELEV_BITS;

  cfg_t          cfg_q;
  logic          q_full, q_empty, q_push, q_pop, stage_vld, back_idle;
  logic [EW-1:0] push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.view_row  <= '0;
      cfg_q.view_col  <= '0;
      cfg_q.grid_rows <= 9'd256;
      cfg_q.grid_cols <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VIEW_ROW:  cfg_q.view_row  <= cfg_wdata_i[FieldW-1:0];
        CFG_VIEW_COL:  cfg_q.view_col  <= cfg_wdata_i[FieldW-1:0];
        CFG_GRID_ROWS: cfg_q.grid_rows <= cfg_wdata_i;
        CFG_GRID_COLS: cfg_q.grid_cols <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  gls_front #(
    .GRID_DIM  (GRID_DIM),
    .ELEV_BITS (ELEV_BITS),
    .EW        (EW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .target_row_i (target_row_i),
    .target_col_i (target_col_i),
    .elevation_i  (elevation_i),
    .cfg_i        (cfg_q),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .push_data_o  (push_data),
    .stage_vld_o  (stage_vld)
  );

  gls_fifo #(
    .WIDTH (EW),
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_data),
    .pop_i   (q_pop),
    .rdata_o (pop_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  gls_back #(
    .GRID_DIM  (GRID_DIM),
    .ELEV_BITS (ELEV_BITS),
    .EW        (EW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .q_pop_o     (q_pop),
    .idle_o      (back_idle),
    .done_o      (done_o),
    .query_row_o (query_row_o),
    .query_col_o (query_col_o),
    .visible_o   (visible_o),
    .status_o    (status_o)
  );

  // An error result never reports the target as seen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> !visible_o)
    else $error("error result marked visible");

  // An accepted word is held in the front stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> stage_vld)
    else $error("accepted word lost in front end");

  // A result straight out of the idle back end comes from a popped word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(back_idle) |-> $past(q_pop))
    else $error("result without a queued word");

  // The back end pops only when the queue holds a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty && back_idle)
    else $error("pop from empty queue");

endmodule
